[rtl/bdgt_pkg.sv]
// Shared constants, types and states for the decimal text renderer.
package bdgt_pkg;

  localparam int VALUE_WIDTH  = 64;
  localparam int VALUE_BITS_D = 64;
  localparam int MAX_DIGITS   = 20;
  localparam int DIGIT_BITS   = 4;
  localparam int BCD_BITS     = MAX_DIGITS * DIGIT_BITS;
  localparam int POS_BITS     = $clog2(MAX_DIGITS);
  localparam int GROUP_SIZE   = 3;

  localparam logic [7:0] DEFAULT_SEP = 8'd44;  // ','
  localparam logic [7:0] ASCII_ZERO  = 8'd48;  // '0'

  localparam logic [POS_BITS-1:0] TOP_POS = POS_BITS'(MAX_DIGITS - 1);
  localparam logic [1:0]          TOP_MOD = 2'((MAX_DIGITS - 1) % GROUP_SIZE);

  // Converter to emitter handoff.
  typedef struct packed {
    logic                done;
    logic [BCD_BITS-1:0] bcd;
  } bdgt_bcd_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_DIGIT,
    EM_SEP
  } em_state_t;

endpackage

[rtl/bdgt_dabble.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module bdgt_dabble
  import bdgt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  busy,
  output bdgt_bcd_t             conv
);

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [BCD_BITS-1:0]   bcd;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [CNT_BITS-1:0]   cnt;
  logic                  done;

  // Correct every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bin <= bin << 1;
      bcd <= {bcd_adj[BCD_BITS-2:0], bin[VALUE_BITS-1]};
    end
  end

  assign conv.done = done;
  assign conv.bcd  = bcd;

endmodule

[rtl/bdgt_emit.sv]
// Digit-serial text emitter: skips leading zeros, inserts separators, output register.
module bdgt_emit
  import bdgt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bdgt_bcd_t  conv,
  input  logic [7:0] sep,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] text_char,
  output logic       last_char
);

  em_state_t state, state_next;

  logic [BCD_BITS-1:0] digits, digits_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [1:0]          pos_mod, pos_mod_next;
  logic                started, started_next;
  logic                out_valid_next;
  logic                load;
  logic [7:0]          char_next;
  logic                last_next;
  logic                load_ok;
  logic [3:0]          top_digit;

  assign top_digit = digits[BCD_BITS-1 -: DIGIT_BITS];
  assign load_ok   = !out_valid || !out_stall;
  assign busy      = (state != EM_IDLE);

  always_comb begin
    state_next     = state;
    digits_next    = digits;
    pos_next       = pos;
    pos_mod_next   = pos_mod;
    started_next   = started;
    out_valid_next = out_valid && out_stall;
    load           = 1'b0;
    char_next      = ASCII_ZERO + {4'b0, top_digit};
    last_next      = 1'b0;
    case (state)
      EM_IDLE: begin
        if (conv.done) begin
          digits_next  = conv.bcd;
          pos_next     = TOP_POS;
          pos_mod_next = TOP_MOD;
          started_next = 1'b0;
          state_next   = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (!started && top_digit == 4'd0 && pos != '0) begin
          // leading zero, drop it
          digits_next  = digits << DIGIT_BITS;
          pos_next     = pos - POS_BITS'(1);
          pos_mod_next = (pos_mod == 2'd0) ? 2'd2 : pos_mod - 2'd1;
        end else if (load_ok) begin
          load           = 1'b1;
          out_valid_next = 1'b1;
          last_next      = (pos == '0);
          started_next   = 1'b1;
          if (pos == '0) begin
            state_next = EM_IDLE;
          end else begin
            digits_next  = digits << DIGIT_BITS;
            pos_next     = pos - POS_BITS'(1);
            pos_mod_next = (pos_mod == 2'd0) ? 2'd2 : pos_mod - 2'd1;
            state_next   = (pos_mod == 2'd0) ? EM_SEP : EM_DIGIT;
          end
        end
      end
      EM_SEP: begin
        if (load_ok) begin
          load           = 1'b1;
          out_valid_next = 1'b1;
          char_next      = sep;
          state_next     = EM_DIGIT;
        end
      end
      default: begin
        state_next = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    digits  <= digits_next;
    pos     <= pos_next;
    pos_mod <= pos_mod_next;
    started <= started_next;
    if (load) begin
      text_char <= char_next;
      last_char <= last_next;
    end
  end

endmodule

[rtl/binary_to_decimal_grouped_text.sv]
// Operation: bit-serial conversion, a handoff to the emitter, then the emitter
//   skips leading zero digits (up to 19) and sends one character at a time.
// Input: one number at a time; the shift-and-add-3 converter and the emitter
//   stall it until the final character of the last number has been loaded.
// Reset (rst, synchronous): both units idle, output empty, separator back to ','.
// Top level: decimal text renderer with thousands grouping.
module binary_to_decimal_grouped_text
  import bdgt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_D
) (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  // output channel, one item per character
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             text_char,
  output logic                   last_char,
  // separator register write
  input  logic                   cfg_write,
  input  logic [7:0]             cfg_data
);

  logic       group_separator;
  logic [7:0] sep_reg;
  logic [7:0] sep_eff;
  logic       in_accept;
  logic       conv_busy;
  logic       em_busy;
  bdgt_bcd_t  conv;

  // Separator register; zero means "use the default ','".
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_reg <= DEFAULT_SEP;
    end else if (cfg_write) begin
      sep_reg <= cfg_data;
    end
  end

  assign group_separator = (sep_reg != 8'd0);
  assign sep_eff         = group_separator ? sep_reg : DEFAULT_SEP;

  // One number in flight: hold off while converting, handing off or emitting.
  // A finished last character waiting in the output register does not block.
  assign in_stall  = conv_busy || conv.done || em_busy;
  assign in_accept = in_valid && !in_stall;

  bdgt_dabble #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (in_accept),
    .value (value[VALUE_BITS-1:0]),
    .busy  (conv_busy),
    .conv  (conv)
  );

  bdgt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .conv      (conv),
    .sep       (sep_eff),
    .busy      (em_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .text_char (text_char),
    .last_char (last_char)
  );

`ifndef SYNTHESIS
  // Handoff only reaches an idle emitter.
  a_handoff_idle: assert property (@(posedge clk) disable iff (rst)
    conv.done |-> !em_busy)
    else $error("conversion finished while emitter busy");

  // An accepted item starts the converter.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> conv_busy)
    else $error("accepted item did not start conversion");

  // The emitter only goes idle by loading the final character of a number.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    $fell(em_busy) |-> (out_valid && last_char))
    else $error("emitter went idle without a final character");

  // Output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

[tb/tb_binary_to_decimal_grouped_text.sv]
// Self-checking testbench for the grouped decimal text renderer.
module tb_binary_to_decimal_grouped_text;
  import bdgt_pkg::*;

  // Width the block is built with; the predictor masks to it as the block does.
  localparam int VB = VALUE_BITS_D;
  // Cycle limit for the whole run, set well above the slowest correct run.
  localparam int CYCLE_LIMIT = 500000;
  // Settling time after the last character before the block counts as idle.
  localparam int DRAIN_CYCLES = 30;
  // Long receiver hold-off, far longer than one conversion, so input backs up.
  localparam int HOLD_CYCLES = 600;

  // One expected character on the output channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [VALUE_WIDTH-1:0] value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             text_char;
  logic                   last_char;
  logic                   cfg_write = 1'b0;
  logic [7:0]             cfg_data = '0;

  // Predictor state: separator register as the block should hold it.
  logic [7:0]  sep_reg = DEFAULT_SEP;
  // Characters still owed by the block, oldest first.
  text_item_t  pending_chars[$];

  int          fail_count = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;     // random idling on both channels
  int          holds_asked = 0;    // bumped by a test to ask for a long hold-off
  int          holds_done = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  binary_to_decimal_grouped_text #(
    .VALUE_BITS(VB)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .text_char (text_char),
    .last_char (last_char),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops characters.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // 10**k for k up to 19, used to hit digit count and grouping boundaries.
  function automatic logic [63:0] pow_ten(input int k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return p;
  endfunction

  // Predictor: renders one number as grouped decimal text and queues the
  // characters. Digits are peeled off least significant first, then sent
  // most significant first; a separator follows every digit whose index
  // (counted from the right, from zero) is a nonzero multiple of three.
  function automatic void render_grouped(input logic [VALUE_WIDTH-1:0] num,
                                         input logic [7:0] sep);
    logic [VALUE_WIDTH-1:0] rest;
    logic [3:0]             digs [MAX_DIGITS];
    logic [7:0]             mark;
    text_item_t             it;
    int                     n;
    int                     i;
    rest = num & ({VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - VB));
    // A zero register means no separator chosen: fall back to ','.
    mark = (sep == 8'd0) ? DEFAULT_SEP : sep;
    n = 0;
    // Zero still gives one digit.
    do begin
      digs[n] = 4'(rest % 64'd10);
      rest = rest / 64'd10;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (i = n - 1; i >= 0; i--) begin
      it.ch   = ASCII_ZERO + 8'(digs[i]);
      it.last = (i == 0);
      pending_chars.push_back(it);
      if (i > 0 && (i % GROUP_SIZE) == 0) begin
        it.ch   = mark;
        it.last = 1'b0;
        pending_chars.push_back(it);
      end
    end
  endfunction

  // Receiver: long hold-off when a test asks for one, else random stall
  // bursts with quiet stretches between them.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      holds_done <= holds_done + 1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checker: every character taken from the block is matched against the
  // oldest one still owed.
  always @(posedge clk) begin
    text_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: text_char %0d, last_char %0d", text_char, last_char);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (text_char !== want.ch) begin
          $error("text_char: expected %0d, actual %0d", want.ch, text_char);
          fail_count++;
        end
        if (last_char !== want.last) begin
          $error("last_char: expected %0d, actual %0d", want.last, last_char);
          fail_count++;
        end
      end
    end
  end

  // Offers one number, after a random gap when idling is on, and records
  // its expected text once the block takes it. Valid stays high afterwards
  // so back-to-back items leave no gap between them.
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do begin
      @(posedge clk);
    end while (in_stall);
    render_grouped(v, sep_reg);
  endtask

  // Stops offering and waits until every owed character has come out,
  // then lets the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Separator register write; only done with the block idle.
  task automatic write_separator(input logic [7:0] c);
    wait_idle();
    cfg_data  <= c;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    sep_reg = c;
  endtask

  // Mix of full-width, random-width, power-of-ten boundary and small values.
  function automatic logic [VALUE_WIDTH-1:0] random_value();
    logic [63:0] r;
    int          w;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return r;
      1: begin
        w = $urandom_range(1, 64);
        return r >> (64 - w);
      end
      2: return pow_ten($urandom_range(0, 19)) - 64'($urandom_range(0, 1));
      default: return 64'($urandom_range(0, 999999));
    endcase
  endfunction

  // Edge values: zero, digit count boundaries around the first groups, the
  // largest 19 digit number, the smallest 20 digit number, the largest 64-bit value and alternating bit patterns.
  task automatic test_directed_values();
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd999);
    send_value(64'd1000);
    send_value(64'd9999);
    send_value(64'd12345);
    send_value(64'd999999);
    send_value(64'd1000000);
    send_value(64'd123456789);
    send_value(64'hFFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
    send_value(pow_ten(19) - 64'd1);
    send_value(pow_ten(19));
    send_value(64'h5555_5555_5555_5555);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Separator extremes, the zero fallback and a return to the reset value.
  task automatic test_separators();
    logic [7:0] seps [5];
    seps = '{8'd1, 8'd255, 8'd0, 8'(46), DEFAULT_SEP};
    foreach (seps[s]) begin
      write_separator(seps[s]);
      send_value(64'd1234567);
      send_value(64'hFFFF_FFFF_FFFF_FFFF);
      send_value(64'd999);
      send_value(random_value());
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the
  // block fills and has to stall its input.
  task automatic test_backpressure();
    holds_asked++;
    repeat (10) send_value({$urandom, $urandom});
    wait_idle();
  endtask

  // Bulk random traffic in rounds, each with a fresh separator (zero can be drawn).
  task automatic test_random_values();
    for (int round = 0; round < 4; round++) begin
      write_separator(8'($urandom_range(0, 255)));
      repeat (50) send_value(random_value());
    end
  endtask

  // Last stretch with no idling on either side: back-to-back throughput.
  task automatic test_steady_stream();
    write_separator(8'($urandom_range(1, 255)));
    idle_on = 1'b0;
    repeat (40) send_value(random_value());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_values();
    test_separators();
    test_backpressure();
    test_random_values();
    test_steady_stream();
    wait_idle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bdgt_pkg.sv
rtl/bdgt_dabble.sv
rtl/bdgt_emit.sv
rtl/binary_to_decimal_grouped_text.sv
tb/tb_binary_to_decimal_grouped_text.sv
